FILE: design/dq_pkg.sv
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP_FWD   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DUMP_REV   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

endpackage

FILE: design/double_ended_queue_top.sv
// channel   direction  handshake          fields
// input     in         in_valid/in_stall  func, new_value
// output    out        out_valid/out_stall element_value, front_value, back_value,
//                                         occupancy, status, last
//
// push and pop: one word taken in idle, its result word registered from the exec state
// once the output is free; dump of n elements: n result words, one per cycle while out_stall is low.
// the timing follows from the single slot memory and its registered read.
// rst_n clears the front pointer, the count and the cached end values; slots are not cleared.
// in_stall is high while a word is in work; out_stall holds the result register.
module double_ended_queue_top #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dq_pkg::FUNC_W-1:0]           func,
    input  logic signed [dq_pkg::VALUE_W-1:0]   new_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dq_pkg::VALUE_W-1:0]   element_value,
    output logic signed [dq_pkg::VALUE_W-1:0]   front_value,
    output logic signed [dq_pkg::VALUE_W-1:0]   back_value,
    output logic [$clog2(DEPTH+1)-1:0]          occupancy,
    output logic [dq_pkg::STATUS_W-1:0]         status,
    output logic                                last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = dq_pkg::VALUE_W;
    localparam int SW = dq_pkg::STATUS_W;
    localparam int FW = dq_pkg::FUNC_W;
    localparam logic [AW:0]   DEPTH_SUM = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[AW-1:0];
    endfunction

    dq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]        fidx_reg, fidx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic signed [VW-1:0] front_reg, front_next;
    logic signed [VW-1:0] back_reg, back_next;
    logic [FW-1:0]        func_reg, func_next;
    logic signed [VW-1:0] val_reg, val_next;
    logic signed [VW-1:0] elem_reg, elem_next;
    logic [SW-1:0]        stat_reg, stat_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] out_elem_reg, out_elem_next;
    logic signed [VW-1:0] out_front_reg, out_front_next;
    logic signed [VW-1:0] out_back_reg, out_back_next;
    logic [CW-1:0]        out_occ_reg, out_occ_next;
    logic [SW-1:0]        out_stat_reg, out_stat_next;
    logic                 out_last_reg, out_last_next;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 is_empty;
    logic                 is_full;
    logic                 in_dump;
    logic                 dump_last;
    logic [CW-1:0]        off_cnt;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [VW-1:0]        rd_data;

    dq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != dq_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == DEPTH_CNT);
    assign in_dump   = (func == dq_pkg::FUNC_DUMP_FWD) || (func == dq_pkg::FUNC_DUMP_REV);
    assign dump_last = (idx_reg == count_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_dump && !is_empty)
                    begin
                        state_next = dq_pkg::ST_DUMP;
                    end
                    else if (func <= dq_pkg::FUNC_DUMP_REV)
                    begin
                        state_next = dq_pkg::ST_EXEC;
                    end
                end
            end
            dq_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            dq_pkg::ST_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fidx_next      = fidx_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        func_next      = func_reg;
        val_next       = val_reg;
        elem_next      = elem_reg;
        stat_next      = stat_reg;
        out_load       = 1'b0;
        out_elem_next  = out_elem_reg;
        out_front_next = out_front_reg;
        out_back_next  = out_back_reg;
        out_occ_next   = out_occ_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = fidx_reg;
        wr_data        = new_value;
        rd_en          = 1'b0;
        rd_addr        = fidx_reg;
        off_cnt        = '0;

        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    val_next  = new_value;
                    elem_next = '0;
                    stat_next = dq_pkg::STATUS_OK;
                    idx_next  = '0;
                    unique case (func)
                        dq_pkg::FUNC_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                stat_next = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = (fidx_reg == '0) ? LAST_IDX : fidx_reg - AW'(1);
                                fidx_next  = wr_addr;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dq_pkg::FUNC_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                stat_next = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_add(fidx_reg, count_reg[AW-1:0]);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dq_pkg::FUNC_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // new front comes from the slot after the old one
                                elem_next  = front_reg;
                                rd_en      = 1'b1;
                                rd_addr    = (fidx_reg == LAST_IDX) ? '0 : fidx_reg + AW'(1);
                                fidx_next  = rd_addr;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dq_pkg::FUNC_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                elem_next  = back_reg;
                                off_cnt    = (count_reg >= CW'(2)) ? count_reg - CW'(2) : '0;
                                rd_en      = 1'b1;
                                rd_addr    = ring_add(fidx_reg, off_cnt[AW-1:0]);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dq_pkg::FUNC_DUMP_FWD, dq_pkg::FUNC_DUMP_REV:
                        begin
                            if (is_empty)
                            begin
                                stat_next = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                off_cnt = (func == dq_pkg::FUNC_DUMP_FWD) ? '0
                                          : count_reg - CW'(1);
                                rd_en   = 1'b1;
                                rd_addr = ring_add(fidx_reg, off_cnt[AW-1:0]);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dq_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    if (stat_reg == dq_pkg::STATUS_OK)
                    begin
                        unique case (func_reg)
                            dq_pkg::FUNC_PUSH_FRONT:
                            begin
                                front_next = val_reg;
                                if (count_reg == CW'(1))
                                begin
                                    back_next = val_reg;
                                end
                            end
                            dq_pkg::FUNC_PUSH_BACK:
                            begin
                                back_next = val_reg;
                                if (count_reg == CW'(1))
                                begin
                                    front_next = val_reg;
                                end
                            end
                            dq_pkg::FUNC_POP_FRONT:
                            begin
                                front_next = is_empty ? '0 : rd_data;
                                if (is_empty)
                                begin
                                    back_next = '0;
                                end
                            end
                            dq_pkg::FUNC_POP_BACK:
                            begin
                                back_next = is_empty ? '0 : rd_data;
                                if (is_empty)
                                begin
                                    front_next = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    out_load       = 1'b1;
                    out_elem_next  = elem_reg;
                    out_front_next = front_next;
                    out_back_next  = back_next;
                    out_occ_next   = count_reg;
                    out_stat_next  = stat_reg;
                    out_last_next  = 1'b1;
                end
            end
            dq_pkg::ST_DUMP:
            begin
                // read data holds while the result register is stalled
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_elem_next  = rd_data;
                    out_front_next = front_reg;
                    out_back_next  = back_reg;
                    out_occ_next   = count_reg;
                    out_stat_next  = dq_pkg::STATUS_OK;
                    out_last_next  = dump_last;
                    if (!dump_last)
                    begin
                        idx_next = idx_reg + CW'(1);
                        off_cnt  = (func_reg == dq_pkg::FUNC_DUMP_FWD) ? idx_reg + CW'(1)
                                   : count_reg - CW'(2) - idx_reg;
                        rd_en    = 1'b1;
                        rd_addr  = ring_add(fidx_reg, off_cnt[AW-1:0]);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::ST_IDLE;
            fidx_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fidx_reg      <= fidx_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        val_reg       <= val_next;
        elem_reg      <= elem_next;
        stat_reg      <= stat_next;
        out_elem_reg  <= out_elem_next;
        out_front_reg <= out_front_next;
        out_back_reg  <= out_back_next;
        out_occ_reg   <= out_occ_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign element_value = out_elem_reg;
    assign front_value   = out_front_reg;
    assign back_value    = out_back_reg;
    assign occupancy     = out_occ_reg;
    assign status        = out_stat_reg;
    assign last          = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("element count above depth");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_empty
         && (func == dq_pkg::FUNC_POP_FRONT || func == dq_pkg::FUNC_POP_BACK))
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not take one element");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::ST_DUMP && out_load && dump_last)
        |=> (state_reg == dq_pkg::ST_IDLE && out_valid_reg && out_last_reg))
        else $error("dump did not close with a last word");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        is_empty |-> (front_reg == '0 && back_reg == '0) || state_reg != dq_pkg::ST_IDLE)
        else $error("empty queue holds stale end values");
`endif

endmodule

FILE: design/dq_ram.sv
module dq_ram #(
    parameter int WIDTH = dq_pkg::VALUE_W,
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
